// ===== sv/sdc_pkg.sv =====
// Shared types, constants and compare helpers of the swinging door compressor.
package sdc_pkg;

  localparam int TIME_BITS = 32;
  localparam logic [31:0] TIME_MASK =
    (TIME_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TIME_BITS) - 64'd1);
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_SECOND,
    KIND_REST
  } kind_e;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [31:0] sample_value;
    logic [7:0]         sample_quality;
    logic               batch_last;
    kind_e              kind;
  } item_t;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SLOPE,
    ST_L1,
    ST_L2,
    ST_U1,
    ST_U2,
    ST_UC,
    ST_C1,
    ST_C2,
    ST_CC,
    ST_CLOSE,
    ST_RESTART,
    ST_FINAL
  } state_e;

  function automatic logic [33:0] mag(input logic signed [33:0] x);
    mag = x[33] ? 34'(-x) : 34'(x);
  endfunction

  // sign of a*b - c*d given m1 = |a|*b and m2 = |c|*d, b and d positive
  function automatic cmp_e cross_cmp(input logic signed [33:0] a,
                                     input logic signed [33:0] c,
                                     input logic [65:0] m1,
                                     input logic [65:0] m2);
    logic signed [1:0] sa;
    logic signed [1:0] sc;
    cmp_e r;
    sa = a[33] ? -2'sd1 : ((a == '0) ? 2'sd0 : 2'sd1);
    sc = c[33] ? -2'sd1 : ((c == '0) ? 2'sd0 : 2'sd1);
    if (m1 > m2) r = CMP_GT;
    else if (m1 < m2) r = CMP_LT;
    else r = CMP_EQ;
    if (sa != sc) begin
      cross_cmp = (sa > sc) ? CMP_GT : CMP_LT;
    end else if (sa == 2'sd0) begin
      cross_cmp = CMP_EQ;
    end else if (sa < 2'sd0) begin
      cross_cmp = (r == CMP_GT) ? CMP_LT : ((r == CMP_LT) ? CMP_GT : CMP_EQ);
    end else begin
      cross_cmp = r;
    end
  endfunction

endpackage

// ===== sv/sdc_if.sv =====
// Valid/ready stream interfaces for samples in and retained points out.
interface sdc_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        sample_time;
  logic signed [31:0] sample_value;
  logic [7:0]         sample_quality;
  logic               batch_last;

  modport source (output valid, sample_time, sample_value, sample_quality, batch_last,
                  input ready);
  modport sink (input valid, sample_time, sample_value, sample_quality, batch_last,
                output ready);
endinterface

interface sdc_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        kept_time;
  logic signed [31:0] kept_value;
  logic [7:0]         kept_quality;
  logic               batch_end;

  modport source (output valid, kept_time, kept_value, kept_quality, batch_end,
                  input ready);
  modport sink (input valid, kept_time, kept_value, kept_quality, batch_end,
                output ready);
endinterface

// ===== sv/swinging_door_compressor.sv =====
// Swinging door trending compressor. The first sample of a batch goes through ST_FIRST. A
// later sample whose time is not after the anchor goes from ST_SLOPE to ST_FINAL. Others
// run the L, U and C compares, plus ST_CLOSE and ST_RESTART when they close the slope
// envelope; waiting on the output register stalls these. The one shared 34x32 multiplier
// forms the six cross products of the three slope compares in turn. A small queue lets
// the input side keep taking samples while the back end works. Up to two retained points
// leave per sample. The user must write the tolerance register while idle; not enforced.
module swinging_door_compressor #(
  parameter int QUEUE_DEPTH = sdc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  sdc_in_if.sink      in_i,
  sdc_out_if.source   out_o
);

  logic           q_push, q_full, q_pop, q_valid;
  sdc_pkg::item_t q_wdata, q_rdata;

  sdc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  sdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  sdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_o       (out_o)
  );

endmodule

// ===== sv/sdc_front.sv =====
// Front end: accepts samples, masks time and tags each with its batch position.
module sdc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sdc_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output sdc_pkg::item_t q_data_o
);

  sdc_pkg::kind_e pos_q, pos_d;

  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i;

  always_comb begin
    q_data_o.sample_time    = in_i.sample_time & sdc_pkg::TIME_MASK;
    q_data_o.sample_value   = in_i.sample_value;
    q_data_o.sample_quality = in_i.sample_quality;
    q_data_o.batch_last     = in_i.batch_last;
    q_data_o.kind           = pos_q;
  end

  always_comb begin
    pos_d = pos_q;
    if (q_push_o) begin
      if (in_i.batch_last) pos_d = sdc_pkg::KIND_FIRST;
      else if (pos_q == sdc_pkg::KIND_FIRST) pos_d = sdc_pkg::KIND_SECOND;
      else pos_d = sdc_pkg::KIND_REST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pos_q <= sdc_pkg::KIND_FIRST;
    else pos_q <= pos_d;
  end

endmodule

// ===== sv/sdc_queue.sv =====
// Short item queue between front and back end.
module sdc_queue #(
  parameter int DEPTH = sdc_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdc_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sdc_pkg::item_t data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sdc_pkg::item_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== sv/sdc_back.sv =====
// Back end: slope envelope sequencer on one shared multiplier, output register.
module sdc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [30:0]    cfg_wdata_i,
  input  logic           q_valid_i,
  input  sdc_pkg::item_t q_data_i,
  output logic           q_pop_o,
  sdc_out_if.source      out_o
);

  sdc_pkg::state_e state_q, state_d;

  logic [30:0]        tol_q;
  sdc_pkg::item_t     it_q;
  logic [31:0]        at_q, ct_q, let_q, dt_q, ld_q, ud_q;
  logic signed [31:0] av_q, cv_q;
  logic [7:0]         cq_q;
  logic signed [33:0] lo_q, up_q, ln_q, un_q;
  logic [1:0]         open_q;    // [0] lower unbounded, [1] upper unbounded
  logic [65:0]        p_q, p1_q;

  logic               out_vld_q;
  logic [31:0]        out_t_q;
  logic signed [31:0] out_v_q;
  logic [7:0]         out_qual_q;
  logic               out_end_q;

  logic               out_free, after, final_emit;
  logic [33:0]        ma;
  logic [31:0]        mb;
  logic signed [33:0] diff, lo_n, up_n, two_e;
  logic               l_upd, u_upd, closes;
  logic               ld_first, ld_close, ld_final;

  assign out_free   = !out_vld_q || out_o.ready;
  assign after      = it_q.sample_time > at_q;
  assign final_emit = it_q.batch_last && (ct_q != let_q);

  assign two_e = {2'b00, tol_q, 1'b0};
  assign diff  = 34'(it_q.sample_value) - 34'(av_q);
  assign lo_n  = diff - two_e;
  assign up_n  = diff + two_e;

  assign l_upd  = open_q[0] ||
                  (sdc_pkg::cross_cmp(lo_q, ln_q, p1_q, p_q) == sdc_pkg::CMP_GT);
  assign u_upd  = open_q[1] ||
                  (sdc_pkg::cross_cmp(up_q, un_q, p1_q, p_q) == sdc_pkg::CMP_LT);
  assign closes = (sdc_pkg::cross_cmp(ln_q, un_q, p1_q, p_q) == sdc_pkg::CMP_GT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdc_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_data_i.kind == sdc_pkg::KIND_FIRST) ? sdc_pkg::ST_FIRST
                                                           : sdc_pkg::ST_SLOPE;
        end
      end
      sdc_pkg::ST_FIRST:   if (out_free) state_d = sdc_pkg::ST_IDLE;
      sdc_pkg::ST_SLOPE:   state_d = after ? sdc_pkg::ST_L1 : sdc_pkg::ST_FINAL;
      sdc_pkg::ST_L1:      state_d = sdc_pkg::ST_L2;
      sdc_pkg::ST_L2:      state_d = sdc_pkg::ST_U1;
      sdc_pkg::ST_U1:      state_d = sdc_pkg::ST_U2;
      sdc_pkg::ST_U2:      state_d = sdc_pkg::ST_UC;
      sdc_pkg::ST_UC:      state_d = sdc_pkg::ST_C1;
      sdc_pkg::ST_C1:      state_d = sdc_pkg::ST_C2;
      sdc_pkg::ST_C2:      state_d = sdc_pkg::ST_CC;
      sdc_pkg::ST_CC:      state_d = closes ? sdc_pkg::ST_CLOSE : sdc_pkg::ST_FINAL;
      sdc_pkg::ST_CLOSE:   if (out_free) state_d = sdc_pkg::ST_RESTART;
      sdc_pkg::ST_RESTART: state_d = sdc_pkg::ST_FINAL;
      sdc_pkg::ST_FINAL: begin
        if (!final_emit || out_free) state_d = sdc_pkg::ST_IDLE;
      end
      default:             state_d = sdc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o  = 1'b0;
    ld_first = 1'b0;
    ld_close = 1'b0;
    ld_final = 1'b0;
    ma       = sdc_pkg::mag(lo_q);
    mb       = ld_q;
    case (state_q)
      sdc_pkg::ST_IDLE:  q_pop_o  = q_valid_i;
      sdc_pkg::ST_FIRST: ld_first = out_free;
      sdc_pkg::ST_L1: begin
        ma = sdc_pkg::mag(lo_q);
        mb = ld_q;
      end
      sdc_pkg::ST_L2: begin
        ma = sdc_pkg::mag(ln_q);
        mb = dt_q;
      end
      sdc_pkg::ST_U1: begin
        ma = sdc_pkg::mag(up_q);
        mb = ud_q;
      end
      sdc_pkg::ST_U2: begin
        ma = sdc_pkg::mag(un_q);
        mb = dt_q;
      end
      sdc_pkg::ST_C1: begin
        ma = sdc_pkg::mag(ln_q);
        mb = ud_q;
      end
      sdc_pkg::ST_C2: begin
        ma = sdc_pkg::mag(un_q);
        mb = ld_q;
      end
      sdc_pkg::ST_CLOSE: ld_close = out_free;
      sdc_pkg::ST_FINAL: ld_final = final_emit && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q  <= ma * mb;
    p1_q <= p_q;

    if (q_pop_o) begin
      it_q <= q_data_i;
      if (q_data_i.kind == sdc_pkg::KIND_SECOND) begin
        ct_q <= q_data_i.sample_time;
        cv_q <= q_data_i.sample_value;
        cq_q <= q_data_i.sample_quality;
      end
    end

    case (state_q)
      sdc_pkg::ST_FIRST: begin
        if (out_free) begin
          at_q  <= it_q.sample_time;
          av_q  <= it_q.sample_value;
          let_q <= it_q.sample_time;
        end
      end
      sdc_pkg::ST_SLOPE: begin
        dt_q <= it_q.sample_time - at_q;
        lo_q <= lo_n;
        up_q <= up_n;
      end
      sdc_pkg::ST_U1: begin
        if (l_upd) begin
          ln_q <= lo_q;
          ld_q <= dt_q;
        end
      end
      sdc_pkg::ST_UC: begin
        if (u_upd) begin
          un_q <= up_q;
          ud_q <= dt_q;
        end
      end
      sdc_pkg::ST_CC: begin
        if (!closes) begin
          ct_q <= it_q.sample_time;
          cv_q <= it_q.sample_value;
          cq_q <= it_q.sample_quality;
        end
      end
      sdc_pkg::ST_CLOSE: begin
        if (out_free) begin
          at_q  <= ct_q;
          av_q  <= cv_q;
          let_q <= ct_q;
          ct_q  <= it_q.sample_time;
          cv_q  <= it_q.sample_value;
          cq_q  <= it_q.sample_quality;
        end
      end
      sdc_pkg::ST_RESTART: begin
        // envelope restarts from the sample that closed it
        if (after) begin
          ln_q <= lo_n;
          un_q <= up_n;
          ld_q <= it_q.sample_time - at_q;
          ud_q <= it_q.sample_time - at_q;
        end
      end
      sdc_pkg::ST_FINAL: begin
        if (ld_final) let_q <= ct_q;
      end
      default: ;
    endcase

    if (ld_first) begin
      out_t_q    <= it_q.sample_time;
      out_v_q    <= it_q.sample_value;
      out_qual_q <= it_q.sample_quality;
      out_end_q  <= it_q.batch_last;
    end else if (ld_close || ld_final) begin
      out_t_q    <= ct_q;
      out_v_q    <= cv_q;
      out_qual_q <= cq_q;
      out_end_q  <= ld_final;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sdc_pkg::ST_IDLE;
      tol_q     <= '0;
      open_q    <= 2'b11;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      if (ld_first || ld_close) open_q <= 2'b11;
      else if (state_q == sdc_pkg::ST_UC) open_q <= 2'b00;
      else if (state_q == sdc_pkg::ST_RESTART && after) open_q <= 2'b00;
      if (ld_first || ld_close || ld_final) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.kept_time    = out_t_q;
  assign out_o.kept_value   = out_v_q;
  assign out_o.kept_quality = out_qual_q;
  assign out_o.batch_end    = out_end_q;

endmodule
